### sv/rdpd_pkg.sv
// rdpd_pkg: shared types and constants for the rotary dial pin decoder
// word formats, event codes, register indexes and reset values
// no dependencies
package rdpd_pkg;

    localparam int PIN_W = 32;

    typedef struct packed {
        logic rest_level;
        logic pulse_level;
    } in_word_t;

    typedef struct packed {
        logic [2:0]       event_res;
        logic [3:0]       digit;
        logic [3:0]       digit_count;
        logic [PIN_W-1:0] pin_code;
        logic             last;
    } out_word_t;

    typedef struct packed {
        logic [9:0]  debounce_ticks;
        logic [15:0] timeout_ticks;
        logic [3:0]  pin_length;
    } cfg_t;

    typedef struct packed {
        logic [1:0] cnt;
        out_word_t  w0;
        out_word_t  w1;
    } res_bundle_t;

    localparam logic [2:0] EV_START   = 3'd0;
    localparam logic [2:0] EV_PULSE   = 3'd1;
    localparam logic [2:0] EV_DIGIT   = 3'd2;
    localparam logic [2:0] EV_DONE    = 3'd3;
    localparam logic [2:0] EV_TIMEOUT = 3'd4;

    localparam logic [1:0] REG_DEBOUNCE = 2'd0;
    localparam logic [1:0] REG_TIMEOUT  = 2'd1;
    localparam logic [1:0] REG_PIN_LEN  = 2'd2;

    localparam logic [9:0]  DEBOUNCE_RST = 10'd150;
    localparam logic [15:0] TIMEOUT_RST  = 16'd5000;
    localparam logic [3:0]  PIN_LEN_RST  = 4'd6;

    localparam logic [9:0]  SAE_MAX   = 10'd1023;
    localparam logic [15:0] SDS_MAX   = 16'd65535;
    localparam logic [3:0]  PULSE_MAX = 4'd15;
    localparam logic [3:0]  TEN       = 4'd10;

endpackage

### sv/rdpd_cfg.sv
// rdpd_cfg: apb-style configuration registers
// depends on rdpd_pkg
module rdpd_cfg (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [3:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready,
    output rdpd_pkg::cfg_t      cfg
);
    import rdpd_pkg::*;

    cfg_t       cfg_reg;
    cfg_t       cfg_next;
    logic [1:0] idx;
    logic       wr;

    assign idx    = paddr[3:2];
    assign wr     = psel && penable && pwrite;
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr)
        begin
            case (idx)
                REG_DEBOUNCE: cfg_next.debounce_ticks = pwdata[9:0];
                REG_TIMEOUT:  cfg_next.timeout_ticks  = pwdata[15:0];
                REG_PIN_LEN:  cfg_next.pin_length     = pwdata[3:0];
                default:      cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        case (idx)
            REG_DEBOUNCE: prdata = {22'd0, cfg_reg.debounce_ticks};
            REG_TIMEOUT:  prdata = {16'd0, cfg_reg.timeout_ticks};
            REG_PIN_LEN:  prdata = {28'd0, cfg_reg.pin_length};
            default:      prdata = 32'd0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.debounce_ticks <= DEBOUNCE_RST;
            cfg_reg.timeout_ticks  <= TIMEOUT_RST;
            cfg_reg.pin_length     <= PIN_LEN_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

### sv/rdpd_core.sv
// rdpd_core: input register, dial session state and per-tick decode
// depends on rdpd_pkg
module rdpd_core #(
    parameter int MAX_DIGITS = 8
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    input  rdpd_pkg::in_word_t    in_word,
    output logic                  in_stall,
    input  rdpd_pkg::cfg_t        cfg,
    input  logic                  room,
    output rdpd_pkg::res_bundle_t res
);
    import rdpd_pkg::*;

    localparam int         STORE_W = 4 * MAX_DIGITS;
    localparam logic [3:0] MAX_D   = 4'(MAX_DIGITS);

    logic               in_valid_reg;
    in_word_t           in_word_reg;
    logic               process;

    logic               in_session_reg, in_session_next;
    logic               dialing_reg, dialing_next;
    logic               held_reg, held_next;
    logic [3:0]         pc_reg, pc_next;
    logic [3:0]         idx_reg, idx_next;
    logic [STORE_W-1:0] store_reg, store_next;
    logic [15:0]        sds_reg, sds_next;
    logic [9:0]         sae_reg, sae_next;
    logic               prev_rest_reg, prev_rest_next;

    logic [1:0]         n_v;
    out_word_t          w_v [2];
    logic [3:0]         need;
    logic [3:0]         d_v;
    logic               rest;
    logic               pulse;
    logic               falling;

    function automatic out_word_t mk(input logic [2:0] ev, input logic [3:0] dg,
                                     input logic [3:0] ix, input logic [STORE_W-1:0] st);
        out_word_t w;
        w.event_res   = ev;
        w.digit       = dg;
        w.digit_count = ix;
        w.pin_code    = PIN_W'(st);
        w.last        = 1'b0;
        return w;
    endfunction

    assign process  = in_valid_reg && room;
    assign in_stall = in_valid_reg && !room;

    assign rest    = in_word_reg.rest_level;
    assign pulse   = in_word_reg.pulse_level;
    assign falling = prev_rest_reg && !rest;

    always_comb
    begin
        if (cfg.pin_length == 4'd0)
            need = 4'd1;
        else if (cfg.pin_length > MAX_D)
            need = MAX_D;
        else
            need = cfg.pin_length;
    end

    always_comb
    begin
        in_session_next = in_session_reg;
        dialing_next    = dialing_reg;
        held_next       = held_reg;
        pc_next         = pc_reg;
        idx_next        = idx_reg;
        store_next      = store_reg;
        sds_next        = sds_reg;
        sae_next        = (sae_reg == SAE_MAX) ? sae_reg : sae_reg + 10'd1;
        prev_rest_next  = rest;
        n_v             = 2'd0;
        w_v[0]          = '0;
        w_v[1]          = '0;
        d_v             = 4'd0;

        if (!in_session_reg)
        begin
            if (falling && sae_next >= cfg.debounce_ticks)
            begin
                in_session_next = 1'b1;
                dialing_next    = 1'b1;
                held_next       = 1'b0;
                pc_next         = 4'd0;
                idx_next        = 4'd0;
                store_next      = '0;
                sds_next        = 16'd0;
                sae_next        = 10'd0;
                w_v[n_v[0]]     = mk(EV_START, 4'd0, 4'd0, '0);
                n_v             = n_v + 2'd1;
            end
        end
        else
        begin
            if (sds_next != SDS_MAX)
                sds_next = sds_next + 16'd1;
            if (!rest)
            begin
                if (!dialing_next)
                begin
                    dialing_next = 1'b1;
                    pc_next      = 4'd0;
                    held_next    = 1'b0;
                    sds_next     = 16'd0;
                end
                if (pulse && !held_next)
                begin
                    if (pc_next != PULSE_MAX)
                        pc_next = pc_next + 4'd1;
                    w_v[n_v[0]] = mk(EV_PULSE, 4'd0, idx_next, store_next);
                    n_v         = n_v + 2'd1;
                end
                held_next = pulse;
            end
            else
            begin
                if (dialing_next)
                begin
                    dialing_next = 1'b0;
                    held_next    = 1'b0;
                    if (pc_next != 4'd0)
                    begin
                        d_v = (pc_next >= TEN) ? 4'd0 : pc_next;
                        if (idx_next < MAX_D)
                        begin
                            for (int i = 0; i < MAX_DIGITS; i++)
                            begin
                                if (idx_next == 4'(i))
                                    store_next[4*i +: 4] = d_v;
                            end
                            idx_next = idx_next + 4'd1;
                        end
                        w_v[n_v[0]] = mk(EV_DIGIT, d_v, idx_next, store_next);
                        n_v         = n_v + 2'd1;
                    end
                    pc_next = 4'd0;
                end
                if (idx_next >= need || sds_next >= cfg.timeout_ticks)
                begin
                    w_v[n_v[0]] = mk((idx_next >= need) ? EV_DONE : EV_TIMEOUT,
                                     4'd0, idx_next, store_next);
                    n_v             = n_v + 2'd1;
                    in_session_next = 1'b0;
                    dialing_next    = 1'b0;
                    held_next       = 1'b0;
                    pc_next         = 4'd0;
                    idx_next        = 4'd0;
                    store_next      = '0;
                    sds_next        = 16'd0;
                end
            end
        end

        w_v[0].last = (n_v == 2'd1);
        w_v[1].last = 1'b1;
    end

    assign res.cnt = process ? n_v : 2'd0;
    assign res.w0  = w_v[0];
    assign res.w1  = w_v[1];

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
            in_word_reg <= in_word;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg   <= 1'b0;
            in_session_reg <= 1'b0;
            dialing_reg    <= 1'b0;
            held_reg       <= 1'b0;
            pc_reg         <= 4'd0;
            idx_reg        <= 4'd0;
            store_reg      <= '0;
            sds_reg        <= 16'd0;
            sae_reg        <= 10'd0;
            prev_rest_reg  <= 1'b1;
        end
        else
        begin
            if (!in_stall)
                in_valid_reg <= in_valid;
            if (process)
            begin
                in_session_reg <= in_session_next;
                dialing_reg    <= dialing_next;
                held_reg       <= held_next;
                pc_reg         <= pc_next;
                idx_reg        <= idx_next;
                store_reg      <= store_next;
                sds_reg        <= sds_next;
                sae_reg        <= sae_next;
                prev_rest_reg  <= prev_rest_next;
            end
        end
    end

endmodule

### sv/rdpd_obuf.sv
// rdpd_obuf: two-entry result register feeding the output channel
// depends on rdpd_pkg
module rdpd_obuf (
    input  logic                  clk,
    input  logic                  rst_n,
    input  rdpd_pkg::res_bundle_t res,
    output logic                  room,
    output logic                  out_valid,
    output rdpd_pkg::out_word_t   out_word,
    input  logic                  out_stall
);
    import rdpd_pkg::*;

    out_word_t  buf0_reg, buf0_next;
    out_word_t  buf1_reg, buf1_next;
    logic [1:0] cnt_reg, cnt_next;
    logic       pop;

    assign out_valid = (cnt_reg != 2'd0);
    assign out_word  = buf0_reg;
    assign pop       = out_valid && !out_stall;
    assign room      = (cnt_reg == 2'd0) || (cnt_reg == 2'd1 && pop);

    always_comb
    begin
        buf0_next = buf0_reg;
        buf1_next = buf1_reg;
        cnt_next  = cnt_reg - {1'b0, pop};
        if (res.cnt != 2'd0)
        begin
            buf0_next = res.w0;
            buf1_next = res.w1;
            cnt_next  = res.cnt;
        end
        else if (pop)
        begin
            buf0_next = buf1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        buf0_reg <= buf0_next;
        buf1_reg <= buf1_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cnt_reg <= 2'd0;
        else
            cnt_reg <= cnt_next;
    end

endmodule

### sv/rotary_dial_pin_decoder.sv
// rotary_dial_pin_decoder: top level of the rotary dial pin decoder
// depends on rdpd_pkg, rdpd_cfg, rdpd_core, rdpd_obuf
//
// Each input word is one tick sampling the dial rest and pulse contacts. A
// debounced falling edge on the rest contact opens a session; pulses counted
// while the dial is off normal become a digit when it returns to rest, and
// after pin_length digits the packed code is reported, or the session ends
// after timeout_ticks with no new dial start. A tick is registered on entry,
// decoded combinationally and its results written to a two-entry result register,
// so a tick's results pass through the input register and the result register
// before they are offered on the output. One tick is taken per cycle
// while the result register can drain; a tick that yields two results holds
// back the input, since the result register must empty before the next
// tick's results are written.
module rotary_dial_pin_decoder #(
    parameter int MAX_DIGITS = 8
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  rdpd_pkg::in_word_t  in_word,
    output logic                out_valid,
    input  logic                out_stall,
    output rdpd_pkg::out_word_t out_word,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [3:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready
);
    import rdpd_pkg::*;

    cfg_t        cfg;
    res_bundle_t res;
    logic        room;

    rdpd_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    rdpd_core #(
        .MAX_DIGITS (MAX_DIGITS)
    ) u_core (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_word  (in_word),
        .in_stall (in_stall),
        .cfg      (cfg),
        .room     (room),
        .res      (res)
    );

    rdpd_obuf u_obuf (
        .clk       (clk),
        .rst_n     (rst_n),
        .res       (res),
        .room      (room),
        .out_valid (out_valid),
        .out_word  (out_word),
        .out_stall (out_stall)
    );

endmodule
